// ===== hdl/aff_pkg.sv =====
package aff_pkg;

    localparam int COORD_FRAC_BITS  = 16;
    localparam int MATRIX_FRAC_BITS = 24;
    localparam int CORDIC_STEPS     = 24;
    localparam int CORDIC_N         = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int CNT_W            = (CORDIC_N > 1) ? $clog2(CORDIC_N) : 1;

    localparam int COORD_W = 32;
    localparam int MAT_W   = 40;
    localparam int ACC_W   = 54;
    localparam int OPA_W   = 34;
    localparam int OPB_W   = 42;
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int CW      = 36;
    localparam int MSHIFT  = MATRIX_FRAC_BITS - COORD_FRAC_BITS;

    localparam logic signed [CW-1:0] Q30_ONE     = 36'sd1073741824;
    localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam longint GAIN_INF  = 64'sd652032874;
    localparam longint GAIN_CORR = 64'sd434688583;
    localparam longint GAIN_START = GAIN_INF +
        ((2 * CORDIC_N < 31) ? (GAIN_CORR >>> (2 * CORDIC_N)) : 64'sd0);

    localparam logic [1:0] KIND_RESET  = 2'd0;
    localparam logic [1:0] KIND_TRANS  = 2'd1;
    localparam logic [1:0] KIND_ROTATE = 2'd2;
    localparam logic [1:0] KIND_APPLY  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_CORDIC, ST_RMAT, ST_UVEC, ST_LMUL, ST_TMUL,
        ST_COMMIT, ST_APPLY, ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_CSTEP, OP_RMAT, OP_UVEC, OP_LMUL, OP_TMUL,
        OP_COMMIT, OP_APPLY, OP_OUT
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [1:0]       i;
        logic [1:0]       j;
        logic [1:0]       k;
        logic [1:0]       sub;
        logic             phase;
        logic             first;
        logic             last;
        logic [CNT_W-1:0] cstep;
    } cmd_t;

    typedef struct packed {
        logic rot_ok;
    } stat_t;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            5'd24: v = 30'd63;
            5'd25: v = 30'd31;
            5'd26: v = 30'd15;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [MAT_W-1:0] sat_mat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'((64'sd1 <<< (MAT_W - 1)) - 64'sd1);
        lo = -hi - ACC_W'(1);
        if (v > hi) begin
            return hi[MAT_W-1:0];
        end else if (v < lo) begin
            return lo[MAT_W-1:0];
        end
        return v[MAT_W-1:0];
    endfunction

endpackage

// ===== hdl/affine_transform_accumulator.sv =====
// Channel   Direction  tdata                                   tuser
// s_axis    in         pos_x,y,z, dir_x,y,z, angle (224 bits)  kind (2 bits)
// m_axis    out        out_x, out_y, out_z (96 bits)           saturated (1 bit)
//
// Reset and translate complete in the cycle their transaction is taken.
// Apply runs twelve multiply-accumulates on the one shared multiplier, then
// presents the result. Rotate runs CORDIC_STEPS CORDIC steps, then 24 + 27 + 9
// multiply-accumulates on the same multiplier; a skipped rotate returns to idle
// after the check.
// Reset (aresetn low) loads the identity into the matrix, as does a reset kind
// transaction. A stalled result holds in the output register.
module affine_transform_accumulator
    import aff_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, angle
    input  logic [7*COORD_W-1:0]  s_axis_tdata,
    // kind
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_x, out_y, out_z
    output logic [3*COORD_W-1:0]  m_axis_tdata,
    // saturated
    output logic [0:0]            m_axis_tuser
);

    cmd_t  cmd;
    stat_t stat;

    aff_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_kind  (s_axis_tuser),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    aff_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_kind  (s_axis_tuser),
        .in_data  (s_axis_tdata),
        .stat     (stat),
        .out_data (m_axis_tdata),
        .out_sat  (m_axis_tuser[0])
    );

endmodule

// ===== hdl/aff_ctrl.sv =====
module aff_ctrl
    import aff_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] s_kind,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  stat_t      stat,
    output cmd_t       cmd
);

    state_t           state_reg, state_next;
    logic [1:0]       i_reg, i_next, j_reg, j_next, k_reg, k_next, sub_reg, sub_next;
    logic             ph_reg, ph_next, mvalid_reg, mvalid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last_sub;

    // Diagonal entries of the rotation have no sine term.
    assign last_sub = (sub_reg == 2'd2) || ((sub_reg == 2'd1) && (i_reg == j_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            sub_reg    <= '0;
            ph_reg     <= 1'b0;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            sub_reg    <= sub_next;
            ph_reg     <= ph_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        sub_next    = sub_reg;
        ph_next     = ph_reg;
        cnt_next    = cnt_reg;
        mvalid_next = mvalid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                i_next   = '0;
                j_next   = '0;
                k_next   = '0;
                sub_next = '0;
                ph_next  = 1'b0;
                cnt_next = '0;
                if (s_valid) begin
                    case (s_kind)
                        KIND_ROTATE: state_next = ST_CHECK;
                        KIND_APPLY:  state_next = ST_APPLY;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CHECK: begin
                state_next = stat.rot_ok ? ST_CORDIC : ST_IDLE;
            end
            ST_CORDIC: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CORDIC_N - 1)) begin
                    state_next = ST_RMAT;
                end
            end
            ST_RMAT: begin
                ph_next = !ph_reg;
                if (ph_reg) begin
                    if (last_sub) begin
                        sub_next = '0;
                        if (j_reg == 2'd2) begin
                            j_next = '0;
                            if (i_reg == 2'd2) begin
                                i_next     = '0;
                                state_next = ST_UVEC;
                            end else begin
                                i_next = i_reg + 2'd1;
                            end
                        end else begin
                            j_next = j_reg + 2'd1;
                        end
                    end else begin
                        sub_next = sub_reg + 2'd1;
                    end
                end
            end
            ST_UVEC: begin
                state_next = ST_LMUL;
            end
            ST_LMUL: begin
                ph_next = !ph_reg;
                if (ph_reg) begin
                    if (k_reg == 2'd2) begin
                        k_next = '0;
                        if (j_reg == 2'd2) begin
                            j_next = '0;
                            if (i_reg == 2'd2) begin
                                i_next     = '0;
                                state_next = ST_TMUL;
                            end else begin
                                i_next = i_reg + 2'd1;
                            end
                        end else begin
                            j_next = j_reg + 2'd1;
                        end
                    end else begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end
            ST_TMUL: begin
                ph_next = !ph_reg;
                if (ph_reg) begin
                    if (k_reg == 2'd2) begin
                        k_next = '0;
                        if (i_reg == 2'd2) begin
                            state_next = ST_COMMIT;
                        end else begin
                            i_next = i_reg + 2'd1;
                        end
                    end else begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end
            ST_COMMIT: begin
                state_next = ST_IDLE;
            end
            ST_APPLY: begin
                ph_next = !ph_reg;
                if (ph_reg) begin
                    if (k_reg == 2'd3) begin
                        k_next = '0;
                        if (i_reg == 2'd2) begin
                            state_next = ST_OUT;
                        end else begin
                            i_next = i_reg + 2'd1;
                        end
                    end else begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end
            ST_OUT: begin
                if (!mvalid_reg || m_ready) begin
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd       = '0;
        cmd.op    = OP_NONE;
        cmd.i     = i_reg;
        cmd.j     = j_reg;
        cmd.k     = k_reg;
        cmd.sub   = sub_reg;
        cmd.phase = ph_reg;
        cmd.cstep = cnt_reg;
        s_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = OP_LOAD;
                end
            end
            ST_CORDIC: cmd.op = OP_CSTEP;
            ST_RMAT: begin
                cmd.op    = OP_RMAT;
                cmd.first = (sub_reg != 2'd2);
                cmd.last  = last_sub;
            end
            ST_UVEC: cmd.op = OP_UVEC;
            ST_LMUL: begin
                cmd.op    = OP_LMUL;
                cmd.first = (k_reg == 2'd0);
                cmd.last  = (k_reg == 2'd2);
            end
            ST_TMUL: begin
                cmd.op    = OP_TMUL;
                cmd.first = (k_reg == 2'd0);
                cmd.last  = (k_reg == 2'd2);
            end
            ST_COMMIT: cmd.op = OP_COMMIT;
            ST_APPLY: begin
                cmd.op    = OP_APPLY;
                cmd.first = (k_reg == 2'd0);
                cmd.last  = (k_reg == 2'd3);
            end
            ST_OUT: begin
                if (!mvalid_reg || m_ready) begin
                    cmd.op = OP_OUT;
                end
            end
            default: cmd.op = OP_NONE;
        endcase
    end

    assign m_valid = mvalid_reg;

endmodule

// ===== hdl/aff_dp.sv =====
module aff_dp
    import aff_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cmd_t                      cmd,
    input  logic [1:0]                in_kind,
    input  logic [7*COORD_W-1:0]      in_data,
    output stat_t                     stat,
    output logic [3*COORD_W-1:0]      out_data,
    output logic                      out_sat
);

    logic signed [MAT_W-1:0]   mat_reg [12];
    logic signed [MAT_W-1:0]   nm_reg [12];
    logic signed [OPA_W-1:0]   r_reg [9];
    logic signed [OPB_W-1:0]   u_reg [3];
    logic signed [COORD_W-1:0] p_reg [3];
    logic signed [COORD_W-1:0] d_reg [3];
    logic signed [COORD_W-1:0] ang_reg;
    logic signed [CW-1:0]      cx_reg, cy_reg, cz_reg;
    logic                      flip_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [COORD_W-1:0] res_reg [3];
    logic                      res_sat_reg;
    logic [3*COORD_W-1:0]      out_data_reg;
    logic                      out_sat_reg;

    logic signed [COORD_W-1:0] in_p [3];
    logic signed [COORD_W-1:0] in_d [3];
    logic signed [COORD_W-1:0] in_ang;
    logic signed [CW-1:0]      z0, s_val, c_val, omc, xs, ys, at;
    logic signed [OPA_W-1:0]   opa;
    logic signed [OPB_W-1:0]   opb;
    logic [PROD_W-1:0]         mag;
    logic [PROD_W-1:0]         rnd;
    logic signed [ACC_W-1:0]   rnd_s, base;
    logic                      term_neg;
    logic [1:0]                kk;
    logic [32:0]               aa, ds;
    logic signed [ACC_W-1:0]   sat_hi, sat_lo;
    logic signed [COORD_W-1:0] res_v;
    logic                      res_clip;

    function automatic logic signed [MAT_W-1:0] to_mat(input logic signed [COORD_W-1:0] c);
        logic signed [MAT_W-1:0] e;
        e = MAT_W'(c);
        return e <<< MSHIFT;
    endfunction

    always_comb begin
        for (int n = 0; n < 3; n++) begin
            in_p[n] = in_data[n*COORD_W +: COORD_W];
            in_d[n] = in_data[(n+3)*COORD_W +: COORD_W];
            if (in_d[n] > 32'sd1073741824) begin
                in_d[n] = 32'sd1073741824;
            end else if (in_d[n] < -32'sd1073741824) begin
                in_d[n] = -32'sd1073741824;
            end
        end
        in_ang = in_data[6*COORD_W +: COORD_W];
        z0     = CW'(in_ang) <<< 1;
    end

    // The rotation is skipped for a tiny angle or a near-zero direction.
    always_comb begin
        aa = ang_reg[31] ? 33'(-(33'(ang_reg))) : 33'(ang_reg);
        ds = 33'(d_reg[0][31] ? -d_reg[0] : d_reg[0])
           + 33'(d_reg[1][31] ? -d_reg[1] : d_reg[1])
           + 33'(d_reg[2][31] ? -d_reg[2] : d_reg[2]);
        stat.rot_ok = (aa > 33'd5) && (ds > 33'd10);
    end

    always_comb begin
        s_val = flip_reg ? -cy_reg : cy_reg;
        c_val = flip_reg ? -cx_reg : cx_reg;
        omc   = Q30_ONE - c_val;
        xs    = cx_reg >>> cmd.cstep;
        ys    = cy_reg >>> cmd.cstep;
        at    = CW'(atan_q30(5'(cmd.cstep)));
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        kk  = 2'd3 - cmd.i - cmd.j;
        opa = '0;
        opb = '0;
        case (cmd.op)
            OP_RMAT: begin
                case (cmd.sub)
                    2'd0: begin
                        opa = OPA_W'(d_reg[cmd.i]);
                        opb = OPB_W'(d_reg[cmd.j]);
                    end
                    2'd1: begin
                        opa = acc_reg[OPA_W-1:0];
                        opb = OPB_W'(omc);
                    end
                    default: begin
                        opa = OPA_W'(d_reg[kk]);
                        opb = OPB_W'(s_val);
                    end
                endcase
            end
            OP_LMUL: begin
                opa = r_reg[cmd.i*3 + cmd.k];
                opb = OPB_W'(mat_reg[4'(cmd.k)*4'd4 + 4'(cmd.j)]);
            end
            OP_TMUL: begin
                opa = r_reg[cmd.i*3 + cmd.k];
                opb = u_reg[cmd.k];
            end
            OP_APPLY: begin
                opa = (cmd.k == 2'd3) ? OPA_W'(64'sd1 <<< COORD_FRAC_BITS)
                                      : OPA_W'(p_reg[cmd.k]);
                opb = OPB_W'(mat_reg[4'(cmd.i)*4'd4 + 4'(cmd.k)]);
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    // Round half away from zero on the magnitude, then restore the sign.
    always_comb begin
        mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        if (cmd.op == OP_APPLY) begin
            rnd = (mag + (PROD_W'(1) << (MATRIX_FRAC_BITS - 1))) >> MATRIX_FRAC_BITS;
        end else begin
            rnd = (mag + (PROD_W'(1) << 29)) >> 30;
        end
        rnd_s = prod_reg[PROD_W-1] ? -ACC_W'(rnd) : ACC_W'(rnd);
        term_neg = (cmd.op == OP_RMAT) && (cmd.sub == 2'd2) &&
                   !(((cmd.i == 2'd1) && (cmd.j == 2'd0)) ||
                     ((cmd.i == 2'd0) && (cmd.j == 2'd2)) ||
                     ((cmd.i == 2'd2) && (cmd.j == 2'd1)));
        base = '0;
        if ((cmd.op == OP_RMAT) && (cmd.sub == 2'd1) && (cmd.i == cmd.j)) begin
            base = ACC_W'(c_val);
        end else if (cmd.op == OP_TMUL) begin
            base = ACC_W'(to_mat(p_reg[cmd.i]));
        end
        acc_next = (cmd.first ? base : acc_reg) + (term_neg ? -rnd_s : rnd_s);
        sat_hi   = ACC_W'(64'sd2147483647);
        sat_lo   = -sat_hi - ACC_W'(1);
        res_clip = (acc_next > sat_hi) || (acc_next < sat_lo);
        if (acc_next > sat_hi) begin
            res_v = sat_hi[COORD_W-1:0];
        end else if (acc_next < sat_lo) begin
            res_v = sat_lo[COORD_W-1:0];
        end else begin
            res_v = acc_next[COORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < 12; n++) begin
                mat_reg[n] <= ((n % 5) == 0) ? MAT_W'(64'sd1 <<< MATRIX_FRAC_BITS) : '0;
            end
        end else begin
            case (cmd.op)
                OP_LOAD: begin
                    for (int n = 0; n < 3; n++) begin
                        p_reg[n] <= in_p[n];
                        d_reg[n] <= in_d[n];
                    end
                    ang_reg <= in_ang;
                    cx_reg  <= CW'(GAIN_START);
                    cy_reg  <= '0;
                    if (z0 > HALF_PI_Q30) begin
                        cz_reg   <= z0 - PI_Q30;
                        flip_reg <= 1'b1;
                    end else if (z0 < -HALF_PI_Q30) begin
                        cz_reg   <= z0 + PI_Q30;
                        flip_reg <= 1'b1;
                    end else begin
                        cz_reg   <= z0;
                        flip_reg <= 1'b0;
                    end
                    if (in_kind == KIND_RESET) begin
                        for (int n = 0; n < 12; n++) begin
                            mat_reg[n] <= ((n % 5) == 0 && n < 12)
                                          ? MAT_W'(64'sd1 <<< MATRIX_FRAC_BITS) : '0;
                        end
                    end else if (in_kind == KIND_TRANS) begin
                        for (int n = 0; n < 3; n++) begin
                            mat_reg[n*4+3] <= sat_mat(ACC_W'(mat_reg[n*4+3])
                                                      + ACC_W'(to_mat(in_p[n])));
                        end
                    end
                end
                OP_CSTEP: begin
                    if (!cz_reg[CW-1]) begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        cz_reg <= cz_reg - at;
                    end else begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        cz_reg <= cz_reg + at;
                    end
                end
                OP_UVEC: begin
                    for (int n = 0; n < 3; n++) begin
                        u_reg[n] <= OPB_W'(mat_reg[n*4+3]) - OPB_W'(to_mat(p_reg[n]));
                    end
                end
                OP_COMMIT: begin
                    for (int n = 0; n < 12; n++) begin
                        mat_reg[n] <= nm_reg[n];
                    end
                end
                OP_OUT: begin
                    out_data_reg <= {res_reg[2], res_reg[1], res_reg[0]};
                    out_sat_reg  <= res_sat_reg;
                end
                OP_RMAT, OP_LMUL, OP_TMUL, OP_APPLY: begin
                    if (!cmd.phase) begin
                        prod_reg <= opa * opb;
                    end else begin
                        acc_reg <= acc_next;
                        if (cmd.last) begin
                            case (cmd.op)
                                OP_RMAT: r_reg[cmd.i*3 + cmd.j] <= acc_next[OPA_W-1:0];
                                OP_LMUL: nm_reg[4'(cmd.i)*4'd4 + 4'(cmd.j)] <=
                                             sat_mat(acc_next);
                                OP_TMUL: nm_reg[4'(cmd.i)*4'd4 + 4'd3] <= sat_mat(acc_next);
                                default: begin
                                    res_reg[cmd.i] <= res_v;
                                    res_sat_reg    <= ((cmd.i == 2'd0) ? 1'b0 : res_sat_reg)
                                                      | res_clip;
                                end
                            endcase
                        end
                    end
                end
                default: begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    assign out_data = out_data_reg;
    assign out_sat  = out_sat_reg;

endmodule
